[rtl/core/tlss_pkg.sv]
// Shared types, constants and codes for the torque-limited speed stepper.
package tlss_pkg;

    // Default parameter values
    localparam int INTERVAL_BITS_DEF = 32;
    localparam int SPEED_BITS_DEF    = 24;

    // Field and register widths
    localparam int MODE_W      = 3;
    localparam int CURRENT_W   = 16;
    localparam int PCT_W       = 7;
    localparam int TORQUE_W    = 24;
    localparam int OUT_SPEED_W = 24;
    localparam int RATE_W      = 27;
    localparam int PPR_W       = 16;
    localparam int VOLTS_W     = 10;
    localparam int THRESH_W    = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 27;

    // Datapath widths: rate*6000 < 2^40, ticks*ppr < 2^56, one extra bit for the divider shift
    localparam int NUM_W  = 40;
    localparam int ALU_W  = 57;
    localparam int MULT_W = 16;

    localparam logic [MULT_W-1:0] SPEED_FACTOR  = 16'd6000;
    localparam logic [MULT_W-1:0] TORQUE_FACTOR = 16'd955;

    // Event codes
    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EDGE     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REGULATE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_START    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STOP     = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PPR         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEP  = 3'd7;

    // Register reset values
    localparam logic [RATE_W-1:0]   TICK_RATE_RST   = 27'd1000000;
    localparam logic [PPR_W-1:0]    PPR_RST         = 16'd256;
    localparam logic [VOLTS_W-1:0]  VOLTS_RST       = 10'd90;
    localparam logic [THRESH_W-1:0] TORQUE_LOW_RST  = 20'd8000;
    localparam logic [THRESH_W-1:0] TORQUE_HIGH_RST = 20'd10000;
    localparam logic [PCT_W-1:0]    SPEED_MIN_RST   = 7'd5;
    localparam logic [PCT_W-1:0]    SPEED_MAX_RST   = 7'd50;
    localparam logic [PCT_W-1:0]    SPEED_STEP_RST  = 7'd5;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [CURRENT_W-1:0] current_ma;
    } in_item_t;

    typedef struct packed {
        logic                   motor_on;
        logic [PCT_W-1:0]       drive_pct;
        logic [OUT_SPEED_W-1:0] speed_centirpm;
        logic [TORQUE_W-1:0]    torque_mnm;
        logic                   status;
    } out_item_t;

    typedef enum logic {
        EK_SPEED,
        EK_TORQUE
    } eng_kind_t;

    typedef struct packed {
        logic      start;
        eng_kind_t kind;
    } eng_req_t;

    typedef enum logic [2:0] {
        ES_IDLE,
        ES_MUL_A,
        ES_CMP,
        ES_MUL_B,
        ES_SAT,
        ES_DIV,
        ES_DONE
    } eng_state_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_DECIDE,
        TS_WAIT,
        TS_COMMIT
    } top_state_t;

endpackage

[rtl/core/torque_limited_speed_stepper.sv]
// Top level of the torque-limited drill speed stepper.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one event per transfer, chosen by
//   in_data.mode: time tick, encoder rising edge, regulate (with a current sample),
//   start or stop. Each event yields exactly one result on the output channel
//   (out_valid / out_stall / out_data): run flag, drive percentage, measured speed,
//   last torque estimate and a status bit that flags a start while already running.
//   Configuration: cfg_wr_en / cfg_index / cfg_wdata write one register per cycle;
//   the user must write only while the block is idle; the block does not enforce it.
// Processing:
//   Tick, start, stop, arming or ignored edges, ignored regulates: DECIDE then COMMIT, no engine.
//   Encoder edge with speed measurement: engine states MUL_A, CMP, MUL_B, SAT, DIV.
//   Regulate while running: engine states MUL_A, MUL_B, SAT, DIV; zero inputs skip to DONE.
//   The engine does a shift-add multiply one multiplier bit per cycle
//   and a restoring divide one quotient bit per cycle, both on one shared adder.
//   One event is processed at a time; in_stall is high from transfer until commit.
// Reset: run flag, drive, tick count, edge flag, speed and torque clear; registers
//   take their documented defaults. No result is pending after reset.
// Output stall: a finished result is held in the output register; the next event
//   may be taken and computed meanwhile, and commits once the register is free.
module torque_limited_speed_stepper #(
    parameter int INTERVAL_BITS = tlss_pkg::INTERVAL_BITS_DEF,
    parameter int SPEED_BITS    = tlss_pkg::SPEED_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  tlss_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output tlss_pkg::out_item_t                out_data,
    input  logic                               cfg_wr_en,
    input  logic [tlss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tlss_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int RES_W = (SPEED_BITS > tlss_pkg::TORQUE_W) ? SPEED_BITS : tlss_pkg::TORQUE_W;
    localparam int PW    = tlss_pkg::PCT_W;
    localparam int TW    = tlss_pkg::TORQUE_W;

    // Configuration registers
    logic [tlss_pkg::RATE_W-1:0]   tick_rate_reg;
    logic [tlss_pkg::PPR_W-1:0]    ppr_reg;
    logic [tlss_pkg::VOLTS_W-1:0]  volts_reg;
    logic [tlss_pkg::THRESH_W-1:0] torque_low_reg;
    logic [tlss_pkg::THRESH_W-1:0] torque_high_reg;
    logic [PW-1:0]                 speed_min_reg;
    logic [PW-1:0]                 speed_max_reg;
    logic [PW-1:0]                 speed_step_reg;

    // Control state
    tlss_pkg::top_state_t state_reg, state_next;
    logic                     running_reg, running_next;
    logic [PW-1:0]            drive_reg, drive_next;
    logic [INTERVAL_BITS-1:0] interval_reg, interval_next;
    logic                     edge_seen_reg, edge_seen_next;
    logic [SPEED_BITS-1:0]    speed_reg, speed_next;
    logic [TW-1:0]            torque_reg, torque_next;
    logic                     out_valid_reg;

    // Payload
    tlss_pkg::in_item_t  item_reg;
    logic [RES_W-1:0]    eng_res_reg;
    tlss_pkg::out_item_t out_reg, out_next;

    tlss_pkg::eng_req_t eng_req;
    logic               eng_done;
    logic [RES_W-1:0]   eng_result;

    logic need_eng;
    logic slot_free;
    logic commit;
    logic status;
    logic [PW:0]   drive_up;
    logic [PW-1:0] drive_down;
    logic [TW-1:0] torque_new;
    logic [31:0]   speed_wide;

    tlss_engine #(
        .INTERVAL_BITS (INTERVAL_BITS),
        .SPEED_BITS    (SPEED_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (eng_req),
        .tick_rate (tick_rate_reg),
        .ppr       (ppr_reg),
        .volts     (volts_reg),
        .current   (item_reg.current_ma),
        .ticks     (interval_reg),
        .speed     (speed_reg),
        .done      (eng_done),
        .result    (eng_result)
    );

    // Only a measured edge or a regulate while running needs the engine
    assign need_eng = running_reg &&
                      (((item_reg.mode == tlss_pkg::MODE_EDGE) && edge_seen_reg) ||
                       (item_reg.mode == tlss_pkg::MODE_REGULATE));
    assign slot_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlss_pkg::TS_IDLE:
            begin
                if (in_valid)
                    state_next = tlss_pkg::TS_DECIDE;
            end
            tlss_pkg::TS_DECIDE:
                state_next = need_eng ? tlss_pkg::TS_WAIT : tlss_pkg::TS_COMMIT;
            tlss_pkg::TS_WAIT:
            begin
                if (eng_done)
                    state_next = tlss_pkg::TS_COMMIT;
            end
            tlss_pkg::TS_COMMIT:
            begin
                if (slot_free)
                    state_next = tlss_pkg::TS_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_stall      = (state_reg != tlss_pkg::TS_IDLE);
        eng_req.start = (state_reg == tlss_pkg::TS_DECIDE) && need_eng;
        eng_req.kind  = (item_reg.mode == tlss_pkg::MODE_EDGE) ? tlss_pkg::EK_SPEED
                                                               : tlss_pkg::EK_TORQUE;
        commit        = (state_reg == tlss_pkg::TS_COMMIT) && slot_free;
    end

    // Event update, applied at commit
    always_comb
    begin
        running_next   = running_reg;
        drive_next     = drive_reg;
        interval_next  = interval_reg;
        edge_seen_next = edge_seen_reg;
        speed_next     = speed_reg;
        torque_next    = torque_reg;
        status         = 1'b0;
        torque_new     = eng_res_reg[TW-1:0];
        drive_up       = {1'b0, drive_reg} + {1'b0, speed_step_reg};
        drive_down     = (drive_reg > speed_step_reg) ? (drive_reg - speed_step_reg) : '0;
        priority case (item_reg.mode)
            tlss_pkg::MODE_TICK:
            begin
                if (!(&interval_reg))
                    interval_next = interval_reg + INTERVAL_BITS'(1);
            end
            tlss_pkg::MODE_EDGE:
            begin
                if (running_reg)
                begin
                    if (edge_seen_reg)
                        speed_next = eng_res_reg[SPEED_BITS-1:0];
                    edge_seen_next = 1'b1;
                    interval_next  = '0;
                end
            end
            tlss_pkg::MODE_REGULATE:
            begin
                if (running_reg)
                begin
                    torque_next = torque_new;
                    if (torque_new < TW'(torque_low_reg))
                        drive_next = (drive_up < {1'b0, speed_max_reg}) ? drive_up[PW-1:0]
                                                                        : speed_max_reg;
                    else if (torque_new > TW'(torque_high_reg))
                        drive_next = (drive_down > speed_min_reg) ? drive_down : speed_min_reg;
                end
            end
            tlss_pkg::MODE_START:
            begin
                if (running_reg)
                    status = 1'b1;
                else
                begin
                    running_next = 1'b1;
                    drive_next   = speed_min_reg;
                end
            end
            tlss_pkg::MODE_STOP:
            begin
                running_next   = 1'b0;
                edge_seen_next = 1'b0;
                interval_next  = '0;
                speed_next     = '0;
            end
            default:
            begin
                // unused event codes only report the state
                status = 1'b0;
            end
        endcase

        speed_wide              = 32'(speed_next);
        out_next.motor_on       = running_next;
        out_next.drive_pct      = drive_next;
        out_next.speed_centirpm = (speed_wide > 32'h00FF_FFFF) ? 24'hFF_FFFF
                                                               : speed_wide[23:0];
        out_next.torque_mnm     = torque_next;
        out_next.status         = status;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg   <= tlss_pkg::TICK_RATE_RST;
            ppr_reg         <= tlss_pkg::PPR_RST;
            volts_reg       <= tlss_pkg::VOLTS_RST;
            torque_low_reg  <= tlss_pkg::TORQUE_LOW_RST;
            torque_high_reg <= tlss_pkg::TORQUE_HIGH_RST;
            speed_min_reg   <= tlss_pkg::SPEED_MIN_RST;
            speed_max_reg   <= tlss_pkg::SPEED_MAX_RST;
            speed_step_reg  <= tlss_pkg::SPEED_STEP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tlss_pkg::REG_TICK_RATE:   tick_rate_reg   <= cfg_wdata[tlss_pkg::RATE_W-1:0];
                tlss_pkg::REG_PPR:         ppr_reg         <= cfg_wdata[tlss_pkg::PPR_W-1:0];
                tlss_pkg::REG_VOLTS:       volts_reg       <= cfg_wdata[tlss_pkg::VOLTS_W-1:0];
                tlss_pkg::REG_TORQUE_LOW:  torque_low_reg  <= cfg_wdata[tlss_pkg::THRESH_W-1:0];
                tlss_pkg::REG_TORQUE_HIGH: torque_high_reg <= cfg_wdata[tlss_pkg::THRESH_W-1:0];
                tlss_pkg::REG_SPEED_MIN:   speed_min_reg   <= cfg_wdata[PW-1:0];
                tlss_pkg::REG_SPEED_MAX:   speed_max_reg   <= cfg_wdata[PW-1:0];
                tlss_pkg::REG_SPEED_STEP:  speed_step_reg  <= cfg_wdata[PW-1:0];
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlss_pkg::TS_IDLE;
            running_reg   <= 1'b0;
            drive_reg     <= '0;
            interval_reg  <= '0;
            edge_seen_reg <= 1'b0;
            speed_reg     <= '0;
            torque_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                running_reg   <= running_next;
                drive_reg     <= drive_next;
                interval_reg  <= interval_next;
                edge_seen_reg <= edge_seen_next;
                speed_reg     <= speed_next;
                torque_reg    <= torque_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            item_reg <= in_data;
        if (eng_done)
            eng_res_reg <= eng_result;
        if (commit)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[rtl/core/tlss_addsub.sv]
// Shared adder/subtractor used by every arithmetic step of the engine.
module tlss_addsub #(
    parameter int W = tlss_pkg::ALU_W
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W-1:0] sum,
    output logic         carry   // on subtract: a >= b
);

    logic [W-1:0] b_x;

    assign b_x = sub ? ~b : b;
    assign {carry, sum} = {1'b0, a} + {1'b0, b_x} + (W+1)'(sub);

endmodule

[rtl/core/tlss_engine.sv]
// Sequenced shift-add multiply and restoring divide for speed and torque.
module tlss_engine #(
    parameter int INTERVAL_BITS = tlss_pkg::INTERVAL_BITS_DEF,
    parameter int SPEED_BITS    = tlss_pkg::SPEED_BITS_DEF,
    localparam int RES_W = (SPEED_BITS > tlss_pkg::TORQUE_W) ? SPEED_BITS : tlss_pkg::TORQUE_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tlss_pkg::eng_req_t              req,
    input  logic [tlss_pkg::RATE_W-1:0]     tick_rate,
    input  logic [tlss_pkg::PPR_W-1:0]      ppr,
    input  logic [tlss_pkg::VOLTS_W-1:0]    volts,
    input  logic [tlss_pkg::CURRENT_W-1:0]  current,
    input  logic [INTERVAL_BITS-1:0]        ticks,
    input  logic [SPEED_BITS-1:0]           speed,
    output logic                            done,
    output logic [RES_W-1:0]                result
);

    localparam int AW    = tlss_pkg::ALU_W;
    localparam int NW    = tlss_pkg::NUM_W;
    localparam int MW    = tlss_pkg::MULT_W;
    localparam int TW    = tlss_pkg::TORQUE_W;
    localparam int CNT_W = $clog2(RES_W + 1);

    tlss_pkg::eng_state_t state_reg, state_next;
    tlss_pkg::eng_kind_t  kind_reg, kind_next;

    logic [AW-1:0]            acc_reg, acc_next;
    logic [AW-1:0]            mcand_reg, mcand_next;
    logic [MW-1:0]            mplier_reg, mplier_next;
    logic [NW-1:0]            num_reg, num_next;
    logic [AW-1:0]            den_reg, den_next;
    logic [AW-1:0]            rem_reg, rem_next;
    logic [RES_W-1:0]         quo_reg, quo_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [INTERVAL_BITS-1:0] ticks_reg, ticks_next;
    logic [tlss_pkg::PPR_W-1:0] ppr_reg, ppr_next;
    logic [RES_W-1:0]         res_reg, res_next;

    logic [AW-1:0] alu_a, alu_b, alu_sum;
    logic          alu_sub, alu_ge;
    logic [NW-1:0] num_hi;
    logic [AW-1:0] rem_shift;
    logic          mul_last;
    logic          zero_in;

    tlss_addsub #(.W(AW)) u_addsub (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_ge)
    );

    // Upper part of the dividend: at or above the divisor means the quotient saturates
    assign num_hi    = (kind_reg == tlss_pkg::EK_SPEED) ? (num_reg >> SPEED_BITS)
                                                        : (num_reg >> TW);
    assign rem_shift = {rem_reg[AW-2:0], num_reg[NW-1]};
    assign mul_last  = (mplier_reg == '0);
    assign zero_in   = (req.kind == tlss_pkg::EK_SPEED) ? ((ticks == '0) || (ppr == '0))
                                                        : (speed == '0);

    // Operand select for the shared adder
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = mcand_reg;
        alu_sub = 1'b0;
        unique case (state_reg)
            tlss_pkg::ES_CMP:
            begin
                alu_a   = AW'(num_reg);
                alu_b   = AW'(ticks_reg);
                alu_sub = 1'b1;
            end
            tlss_pkg::ES_SAT:
            begin
                alu_a   = AW'(num_hi);
                alu_b   = den_reg;
                alu_sub = 1'b1;
            end
            tlss_pkg::ES_DIV:
            begin
                alu_a   = rem_shift;
                alu_b   = den_reg;
                alu_sub = 1'b1;
            end
            tlss_pkg::ES_IDLE, tlss_pkg::ES_MUL_A, tlss_pkg::ES_MUL_B, tlss_pkg::ES_DONE:
            begin
                alu_a   = acc_reg;
                alu_b   = mcand_reg;
                alu_sub = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlss_pkg::ES_IDLE:
            begin
                if (req.start)
                    state_next = zero_in ? tlss_pkg::ES_DONE : tlss_pkg::ES_MUL_A;
            end
            tlss_pkg::ES_MUL_A:
            begin
                if (mul_last)
                    state_next = (kind_reg == tlss_pkg::EK_SPEED) ? tlss_pkg::ES_CMP
                                                                  : tlss_pkg::ES_MUL_B;
            end
            tlss_pkg::ES_CMP:
                state_next = alu_ge ? tlss_pkg::ES_MUL_B : tlss_pkg::ES_DONE;
            tlss_pkg::ES_MUL_B:
            begin
                if (mul_last)
                    state_next = tlss_pkg::ES_SAT;
            end
            tlss_pkg::ES_SAT:
                state_next = alu_ge ? tlss_pkg::ES_DONE : tlss_pkg::ES_DIV;
            tlss_pkg::ES_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                    state_next = tlss_pkg::ES_DONE;
            end
            tlss_pkg::ES_DONE:
                state_next = tlss_pkg::ES_IDLE;
        endcase
    end

    // Datapath
    always_comb
    begin
        kind_next   = kind_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        ticks_next  = ticks_reg;
        ppr_next    = ppr_reg;
        res_next    = res_reg;
        unique case (state_reg)
            tlss_pkg::ES_IDLE:
            begin
                if (req.start)
                begin
                    kind_next  = req.kind;
                    ticks_next = ticks;
                    ppr_next   = ppr;
                    acc_next   = '0;
                    if (req.kind == tlss_pkg::EK_SPEED)
                    begin
                        mcand_next  = AW'(tick_rate);
                        mplier_next = tlss_pkg::SPEED_FACTOR;
                        res_next    = RES_W'({SPEED_BITS{1'b1}});
                    end
                    else
                    begin
                        mcand_next  = AW'(current);
                        mplier_next = MW'(volts);
                        den_next    = AW'(speed);
                        res_next    = RES_W'({TW{1'b1}});
                    end
                end
            end
            tlss_pkg::ES_MUL_A, tlss_pkg::ES_MUL_B:
            begin
                if (!mul_last)
                begin
                    if (mplier_reg[0])
                        acc_next = alu_sum;
                    mcand_next  = {mcand_reg[AW-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[MW-1:1]};
                end
                else if (state_reg == tlss_pkg::ES_MUL_A)
                begin
                    if (kind_reg == tlss_pkg::EK_SPEED)
                        num_next = acc_reg[NW-1:0];
                    else
                    begin
                        mcand_next  = acc_reg;
                        mplier_next = tlss_pkg::TORQUE_FACTOR;
                        acc_next    = '0;
                    end
                end
                else if (kind_reg == tlss_pkg::EK_SPEED)
                    den_next = acc_reg;
                else
                    num_next = acc_reg[NW-1:0];
            end
            tlss_pkg::ES_CMP:
            begin
                // no more ticks than rate*6000 allows, else the speed is zero
                if (!alu_ge)
                    res_next = '0;
                else
                begin
                    mcand_next  = AW'(ticks_reg);
                    mplier_next = ppr_reg;
                    acc_next    = '0;
                end
            end
            tlss_pkg::ES_SAT:
            begin
                if (alu_ge)
                    res_next = (kind_reg == tlss_pkg::EK_SPEED) ? RES_W'({SPEED_BITS{1'b1}})
                                                                : RES_W'({TW{1'b1}});
                else
                begin
                    rem_next = AW'(num_hi);
                    quo_next = '0;
                    if (kind_reg == tlss_pkg::EK_SPEED)
                    begin
                        num_next = num_reg << (NW - SPEED_BITS);
                        cnt_next = CNT_W'(SPEED_BITS);
                    end
                    else
                    begin
                        num_next = num_reg << (NW - TW);
                        cnt_next = CNT_W'(TW);
                    end
                end
            end
            tlss_pkg::ES_DIV:
            begin
                rem_next = alu_ge ? alu_sum : rem_shift;
                quo_next = {quo_reg[RES_W-2:0], alu_ge};
                num_next = {num_reg[NW-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    res_next = {quo_reg[RES_W-2:0], alu_ge};
            end
            tlss_pkg::ES_DONE:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tlss_pkg::ES_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        ticks_reg  <= ticks_next;
        ppr_reg    <= ppr_next;
        res_reg    <= res_next;
    end

    assign done   = (state_reg == tlss_pkg::ES_DONE);
    assign result = res_reg;

endmodule

[rtl/core/tlss_checker.sv]
// Port-level checks for the torque-limited speed stepper, bound to the top level.
module tlss_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input tlss_pkg::out_item_t out_data
);

    // A held result stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed or dropped while stalled");

    // One event at a time: the block is busy right after a transfer
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again before the previous event committed");

    // A rejected start only happens with the motor running
    a_status_running: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.motor_on)
        else $error("start rejected while stopped");

    // Speed is only measured while running and cleared by stop
    a_speed_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.motor_on |-> out_data.speed_centirpm == '0)
        else $error("nonzero speed reported while stopped");

endmodule

bind torque_limited_speed_stepper tlss_checker u_tlss_checker (.*);

[tb/tb_torque_limited_speed_stepper.sv]
// Self-checking testbench for the torque-limited drill speed stepper.
`timescale 1ns / 1ps

module tb_torque_limited_speed_stepper;

    import tlss_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam time         CLK_PERIOD       = 8ns;
    localparam int unsigned RESET_CYCLES     = 10;
    localparam int unsigned TAIL_CYCLES      = 100;     // longer than the slowest event
    localparam int unsigned LONG_HOLD_CYCLES = 400;     // receiver hold-off that backs up the block
    localparam int unsigned TIMEOUT_CYCLES   = 1500000;
    localparam int unsigned MAX_REPORTS      = 10;
    localparam int unsigned PHASE_EVENTS     = 240;
    localparam int          NUM_REGS         = REG_SPEED_STEP + 1;

    // Mode codes the block treats as no-ops
    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    localparam logic [63:0] SPEED_SAT  = (64'd1 << SPEED_BITS_DEF) - 64'd1;
    localparam logic [63:0] TORQUE_SAT = (64'd1 << TORQUE_W) - 64'd1;

    // ------------------------------------------------------------------
    // Predictor plus store of expected results. note_input() runs the
    // event through a software copy of the block, check_result() pops the
    // oldest expected result and compares every field.
    // ------------------------------------------------------------------
    class stepper_scoreboard;
        // register copies
        logic [RATE_W-1:0]   tick_rate;
        logic [PPR_W-1:0]    ppr;
        logic [VOLTS_W-1:0]  volts;
        logic [THRESH_W-1:0] torque_lo;
        logic [THRESH_W-1:0] torque_hi;
        logic [PCT_W-1:0]    pct_min;
        logic [PCT_W-1:0]    pct_max;
        logic [PCT_W-1:0]    pct_step;
        // block state
        bit                          running;
        logic [PCT_W-1:0]            drive;
        logic [INTERVAL_BITS_DEF-1:0] ticks_since_edge;
        bit                          edge_seen;
        logic [SPEED_BITS_DEF-1:0]   speed;
        logic [TORQUE_W-1:0]         torque;

        out_item_t   result_q[$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            tick_rate        = TICK_RATE_RST;
            ppr              = PPR_RST;
            volts            = VOLTS_RST;
            torque_lo        = TORQUE_LOW_RST;
            torque_hi        = TORQUE_HIGH_RST;
            pct_min          = SPEED_MIN_RST;
            pct_max          = SPEED_MAX_RST;
            pct_step         = SPEED_STEP_RST;
            running          = 1'b0;
            drive            = '0;
            ticks_since_edge = '0;
            edge_seen        = 1'b0;
            speed            = '0;
            torque           = '0;
            mismatches       = 0;
            checked          = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TICK_RATE:   tick_rate = data[RATE_W-1:0];
                REG_PPR:         ppr       = data[PPR_W-1:0];
                REG_VOLTS:       volts     = data[VOLTS_W-1:0];
                REG_TORQUE_LOW:  torque_lo = data[THRESH_W-1:0];
                REG_TORQUE_HIGH: torque_hi = data[THRESH_W-1:0];
                REG_SPEED_MIN:   pct_min   = data[PCT_W-1:0];
                REG_SPEED_MAX:   pct_max   = data[PCT_W-1:0];
                REG_SPEED_STEP:  pct_step  = data[PCT_W-1:0];
                default: ;
            endcase
        endfunction

        // centi-rpm from the tick count; zero divisor saturates
        function logic [SPEED_BITS_DEF-1:0] speed_from_ticks();
            logic [63:0] num;
            logic [63:0] q;
            num = 64'(tick_rate) * 64'(SPEED_FACTOR);
            if (ticks_since_edge == '0 || ppr == '0)
                return SPEED_SAT[SPEED_BITS_DEF-1:0];
            q = num / (64'(ticks_since_edge) * 64'(ppr));
            if (q > SPEED_SAT)
                q = SPEED_SAT;
            return q[SPEED_BITS_DEF-1:0];
        endfunction

        // torque estimate and one drive step; zero speed means worst-case torque
        function void regulate(logic [CURRENT_W-1:0] cur);
            logic [63:0] q;
            int          up;
            int          down;
            if (speed == '0) begin
                q = TORQUE_SAT;
            end
            else begin
                q = (64'(volts) * 64'(cur) * 64'(TORQUE_FACTOR)) / 64'(speed);
                if (q > TORQUE_SAT)
                    q = TORQUE_SAT;
            end
            torque = q[TORQUE_W-1:0];
            if (q < 64'(torque_lo)) begin
                up    = int'(drive) + int'(pct_step);
                drive = (up < int'(pct_max)) ? PCT_W'(up) : pct_max;
            end
            else if (q > 64'(torque_hi)) begin
                down  = (drive > pct_step) ? int'(drive) - int'(pct_step) : 0;
                drive = (down > int'(pct_min)) ? PCT_W'(down) : pct_min;
            end
        endfunction

        function void note_input(in_item_t it);
            out_item_t want;
            bit        rejected;
            rejected = 1'b0;
            case (it.mode)
                MODE_TICK: begin
                    if (ticks_since_edge != '1)
                        ticks_since_edge++;
                end
                MODE_EDGE: begin
                    if (running) begin
                        if (edge_seen)
                            speed = speed_from_ticks();
                        edge_seen        = 1'b1;
                        ticks_since_edge = '0;
                    end
                end
                MODE_REGULATE: begin
                    if (running)
                        regulate(it.current_ma);
                end
                MODE_START: begin
                    if (running) begin
                        rejected = 1'b1;
                    end
                    else begin
                        running = 1'b1;
                        drive   = pct_min;
                    end
                end
                MODE_STOP: begin
                    running          = 1'b0;
                    edge_seen        = 1'b0;
                    ticks_since_edge = '0;
                    speed            = '0;
                end
                default: ;
            endcase
            want.motor_on       = running;
            want.drive_pct      = drive;
            want.speed_centirpm = OUT_SPEED_W'(speed);
            want.torque_mnm     = torque;
            want.status         = rejected;
            result_q.push_back(want);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            checked++;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result %0d arrived with nothing expected: on %0d drv %0d spd %0d trq %0d st %0d",
                             $time, checked, got.motor_on, got.drive_pct, got.speed_centirpm,
                             got.torque_mnm, got.status);
                return;
            end
            want = result_q.pop_front();
            if (got.motor_on !== want.motor_on || got.drive_pct !== want.drive_pct ||
                got.speed_centirpm !== want.speed_centirpm ||
                got.torque_mnm !== want.torque_mnm || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result %0d (exp/got): on %0d/%0d drv %0d/%0d spd %0d/%0d trq %0d/%0d st %0d/%0d",
                             $time, checked, want.motor_on, got.motor_on,
                             want.drive_pct, got.drive_pct,
                             want.speed_centirpm, got.speed_centirpm,
                             want.torque_mnm, got.torque_mnm, want.status, got.status);
            end
        endfunction

        function int unsigned pending();
            return result_q.size();
        endfunction

        function bit clean();
            return (mismatches == 0) && (result_q.size() == 0);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_stall;
    out_item_t              out_data;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    torque_limited_speed_stepper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    stepper_scoreboard         sb;
    logic [CFG_DATA_W-1:0]     cfg_next [NUM_REGS];
    bit                        quiet;          // no idling on either side
    bit                        long_hold_req;  // asks the receiver for one long hold-off
    bit                        gen_running;    // run flag as the stimulus believes it to be
    int unsigned               sent_events;

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial begin : clock_gen
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("timeout after %0d cycles, %0d results still expected",
                 TIMEOUT_CYCLES, sb.pending());
        $display("** torque_limited_speed_stepper: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Monitor: every transfer on either channel goes to the scoreboard.
    // Inputs are noted before outputs are checked; a result never leaves
    // in the same cycle its event enters, so the order is safe.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_input(in_data);
            if (out_valid && !out_stall)
                sb.check_result(out_data);
        end
    end

    // ------------------------------------------------------------------
    // Receiver side: random stall bursts, plus one long hold-off when the
    // stimulus asks for it so the output register and the engine both fill
    // and in_stall is forced high while events keep being offered.
    // ------------------------------------------------------------------
    initial begin : result_sink
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 11) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------

    // One event transfer. Called at a rising edge; returns at the edge where
    // the transfer happened (valid still high) or after a random gap.
    task automatic send_event(input logic [MODE_W-1:0] mode, input logic [CURRENT_W-1:0] cur);
        in_item_t it;
        it.mode       = mode;
        it.current_ma = cur;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_events++;
        if (mode == MODE_START)
            gen_running = 1'b1;
        else if (mode == MODE_STOP)
            gen_running = 1'b0;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every expected result has been taken.
    // The first edge lets the monitor record the last transfer.
    task automatic wait_drained();
        if (in_valid)
            in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic void set_cfg(input logic [CFG_DATA_W-1:0] rate, ppr_val, volts,
                                    lo, hi, pmin, pmax, pstep);
        cfg_next[REG_TICK_RATE]   = rate;
        cfg_next[REG_PPR]         = ppr_val;
        cfg_next[REG_VOLTS]       = volts;
        cfg_next[REG_TORQUE_LOW]  = lo;
        cfg_next[REG_TORQUE_HIGH] = hi;
        cfg_next[REG_SPEED_MIN]   = pmin;
        cfg_next[REG_SPEED_MAX]   = pmax;
        cfg_next[REG_SPEED_STEP]  = pstep;
    endfunction

    // Writes all registers back to back; only called with the block idle.
    task automatic apply_config();
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= cfg_next[i];
            sb.set_reg(CFG_IDX_W'(i), cfg_next[i]);
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CURRENT_W-1:0] pick_current();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return CURRENT_W'($urandom_range(0, 2000));
            default: return CURRENT_W'($urandom);
        endcase
    endfunction

    // Mostly well-formed drilling: start, a run of ticks, an encoder edge,
    // a few regulates. The rest is stray starts/stops/edges and raw noise.
    task automatic random_burst();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (!gen_running && pick < 85) begin
            send_event(MODE_START, CURRENT_W'($urandom));
        end
        else if (pick < 62) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 150) : $urandom_range(0, 12);
            repeat (n) send_event(MODE_TICK, CURRENT_W'($urandom));
            send_event(MODE_EDGE, CURRENT_W'($urandom));
            repeat ($urandom_range(0, 5)) send_event(MODE_REGULATE, pick_current());
        end
        else if (pick < 74) begin
            send_event(MODE_REGULATE, pick_current());
        end
        else if (pick < 79) begin
            send_event(MODE_STOP, CURRENT_W'($urandom));
        end
        else if (pick < 83) begin
            send_event(MODE_START, CURRENT_W'($urandom));
        end
        else if (pick < 91) begin
            send_event(MODE_EDGE, CURRENT_W'($urandom));
        end
        else begin
            send_event(MODE_W'($urandom), CURRENT_W'($urandom));
        end
    endtask

    task automatic run_phase(input int unsigned n_events);
        int unsigned target;
        target = sent_events + n_events;
        while (sent_events < target)
            random_burst();
    endtask

    function automatic void random_cfg();
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        lo = $urandom_range(0, 40000);
        hi = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1000000)
                                          : lo + $urandom_range(0, 20000);
        set_cfg($urandom_range(1, 100000000),
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 1024),
                $urandom_range(0, 1000), lo, hi,
                $urandom_range(0, 100), $urandom_range(0, 100), $urandom_range(0, 100));
    endfunction

    // Directed opening at reset settings: ignored events while stopped,
    // repeated start, zero-speed regulate, back-to-back edges, reserved modes.
    task automatic directed_events();
        send_event(MODE_REGULATE, '1);       // stopped: ignored
        send_event(MODE_EDGE, '0);           // stopped: ignored
        send_event(MODE_STOP, '1);           // stop while stopped
        send_event(MODE_START, '0);
        send_event(MODE_START, '1);          // already running: rejected
        send_event(MODE_REGULATE, '1);       // no speed yet: torque pinned at max
        send_event(MODE_EDGE, '0);           // first edge only arms
        send_event(MODE_EDGE, '1);           // zero ticks: speed saturates
        send_event(MODE_REGULATE, '0);       // zero torque: drive steps up
        repeat (5) send_event(MODE_TICK, '1);
        send_event(MODE_EDGE, '0);           // real speed measurement
        send_event(MODE_REGULATE, 16'd1000);
        send_event(MODE_SPARE_5, '1);
        send_event(MODE_SPARE_6, '0);
        send_event(MODE_SPARE_7, '1);
        send_event(MODE_REGULATE, '1);
        send_event(MODE_STOP, '0);
        send_event(MODE_TICK, '0);           // ticks count while stopped too
        send_event(MODE_START, '1);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        sb            = new();
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        gen_running   = 1'b0;
        sent_events   = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_events();
        wait_drained();

        // reset values written explicitly
        set_cfg(TICK_RATE_RST, PPR_RST, VOLTS_RST, TORQUE_LOW_RST, TORQUE_HIGH_RST,
                SPEED_MIN_RST, SPEED_MAX_RST, SPEED_STEP_RST);
        apply_config();
        run_phase(PHASE_EVENTS);
        wait_drained();

        // top extremes: fast tick clock, one pulse per rev, zero thresholds, full step;
        // a long receiver hold-off lands in the middle
        set_cfg(100000000, 1, 1000, 0, 0, 0, 100, 100);
        apply_config();
        run_phase(80);
        long_hold_req = 1'b1;
        run_phase(PHASE_EVENTS - 80);
        wait_drained();

        // bottom extremes: speed rounds to zero, thresholds at top, min above max;
        // the sender pauses midway until every result is back
        set_cfg(1, 65535, 0, 1000000, 1000000, 100, 0, 0);
        apply_config();
        run_phase(120);
        wait_drained();
        run_phase(PHASE_EVENTS - 120);
        wait_drained();

        // zero pulses per rev: every measured edge saturates
        set_cfg(TICK_RATE_RST, 0, VOLTS_RST, TORQUE_LOW_RST, TORQUE_HIGH_RST,
                SPEED_MIN_RST, SPEED_MAX_RST, 1);
        apply_config();
        run_phase(PHASE_EVENTS);
        wait_drained();

        repeat (3) begin
            random_cfg();
            apply_config();
            run_phase(PHASE_EVENTS);
            wait_drained();
        end

        // last stretch at full rate, no idling on either side
        quiet = 1'b1;
        set_cfg(TICK_RATE_RST, PPR_RST, VOLTS_RST, TORQUE_LOW_RST, TORQUE_HIGH_RST,
                SPEED_MIN_RST, SPEED_MAX_RST, SPEED_STEP_RST);
        apply_config();
        run_phase(PHASE_EVENTS);
        wait_drained();

        // catch any stray result after the last expected one
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
            $display("%0d expected results never arrived", sb.pending());
        if (sb.clean())
            $display("** torque_limited_speed_stepper: PASSED **");
        else
            $display("** torque_limited_speed_stepper: FAILED **");
        $finish;
    end

endmodule

[torque_limited_speed_stepper.f]
rtl/core/tlss_pkg.sv
rtl/core/tlss_addsub.sv
rtl/core/tlss_engine.sv
rtl/core/torque_limited_speed_stepper.sv
rtl/core/tlss_checker.sv
tb/tb_torque_limited_speed_stepper.sv
